// ===== design/kline_frame_receiver_macros.svh =====
`ifndef KLINE_FRAME_RECEIVER_MACROS_SVH
`define KLINE_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KFR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define KFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/kfr_pkg.sv =====
package kfr_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_TICK  = 2'd2
  } kfr_cmd_e;

  localparam logic [7:0] HDR_LEN_MASK = 8'h3F;
  localparam logic [7:0] HDR_EXTRA    = 8'd4;

  typedef struct packed {
    kfr_cmd_e    cmd;
    logic [7:0]  rx_byte;
    logic [7:0]  expected_length;
    logic        verify_frame;
    logic [15:0] ms_budget;
  } kfr_in_t;

  typedef struct packed {
    logic       byte_written;
    logic [7:0] stored_byte;
    logic [7:0] byte_index;
    logic       finished;
    logic       timed_out;
    logic       checksum_ok;
    logic [7:0] result_length;
  } kfr_out_t;

endpackage

// ===== design/kfr_in_stage.sv =====
module kfr_in_stage
  import kfr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  kfr_in_t in_data_i,
  output logic    item_valid_o,
  input  logic    item_take_i,
  output kfr_in_t item_o
);

  logic    valid_q, valid_d;
  kfr_in_t data_q;
  logic    load;

  assign in_ready_o = !valid_q || item_take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (item_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = data_q;

endmodule

// ===== design/kfr_core.sv =====
`include "kline_frame_receiver_macros.svh"

module kfr_core
  import kfr_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 255
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     item_valid_i,
  input  kfr_in_t  item_i,
  output logic     res_valid_o,
  output kfr_out_t res_o
);

  localparam logic [7:0] MaxTarget = 8'(MAX_FRAME_BYTES);

  function automatic logic [7:0] clip_target(input logic [7:0] n);
    clip_target = (n > MaxTarget) ? MaxTarget : n;
  endfunction

  logic        busy_q, busy_d;
  logic        length_known_q, length_known_d;
  logic [7:0]  target_q, target_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  latest_q, latest_d;
  logic [15:0] ms_q, ms_d;
  logic        verify_q, verify_d;

  logic [7:0]  count_inc;
  logic [7:0]  sum_inc;
  logic [7:0]  hdr_len;
  logic        ok_byte;
  logic        ok_tick;

  assign count_inc = count_q + 8'd1;
  assign sum_inc   = sum_q + item_i.rx_byte;
  assign hdr_len   = (item_i.rx_byte & HDR_LEN_MASK) + HDR_EXTRA;
  // Sum of earlier bytes equals the last byte.
  assign ok_byte   = (count_inc != 8'd0) && (sum_q == item_i.rx_byte);
  assign ok_tick   = (count_q != 8'd0) && ((sum_q - latest_q) == latest_q);

  always_comb begin
    busy_d         = busy_q;
    length_known_d = length_known_q;
    target_d       = target_q;
    count_d        = count_q;
    sum_d          = sum_q;
    latest_d       = latest_q;
    ms_d           = ms_q;
    verify_d       = verify_q;
    res_valid_o    = 1'b0;
    res_o          = '0;
    if (item_valid_i) begin
      unique case (item_i.cmd)
        CMD_START: begin
          busy_d         = 1'b1;
          length_known_d = item_i.expected_length != 8'd0;
          target_d       = clip_target(item_i.expected_length);
          count_d        = 8'd0;
          sum_d          = 8'd0;
          latest_d       = 8'd0;
          ms_d           = item_i.ms_budget;
          verify_d       = item_i.verify_frame;
        end
        CMD_BYTE: begin
          if (busy_q) begin
            res_valid_o        = 1'b1;
            res_o.byte_written = 1'b1;
            res_o.stored_byte  = item_i.rx_byte;
            res_o.byte_index   = count_q;
            latest_d           = item_i.rx_byte;
            sum_d              = sum_inc;
            count_d            = count_inc;
            if (!length_known_q) begin
              target_d       = clip_target(hdr_len);
              length_known_d = 1'b1;
            end else if (count_inc >= target_q) begin
              busy_d              = 1'b0;
              res_o.finished      = 1'b1;
              res_o.checksum_ok   = ok_byte;
              res_o.result_length = (verify_q && !ok_byte) ? 8'd0 : count_inc;
            end
          end
        end
        CMD_TICK: begin
          if (busy_q) begin
            if (ms_q <= 16'd1) begin
              ms_d                = 16'd0;
              busy_d              = 1'b0;
              res_valid_o         = 1'b1;
              res_o.finished      = 1'b1;
              res_o.timed_out     = 1'b1;
              res_o.checksum_ok   = ok_tick;
              res_o.result_length = (verify_q && !ok_tick) ? 8'd0 : count_q;
            end else begin
              ms_d = ms_q - 16'd1;
            end
          end
        end
        default: begin
          // unused code: drop
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q         <= 1'b0;
      length_known_q <= 1'b0;
      target_q       <= 8'd0;
      count_q        <= 8'd0;
      sum_q          <= 8'd0;
      latest_q       <= 8'd0;
      ms_q           <= 16'd0;
      verify_q       <= 1'b0;
    end else begin
      busy_q         <= busy_d;
      length_known_q <= length_known_d;
      target_q       <= target_d;
      count_q        <= count_d;
      sum_q          <= sum_d;
      latest_q       <= latest_d;
      ms_q           <= ms_d;
      verify_q       <= verify_d;
    end
  end

  `KFR_ASSERT_NOW(a_res_needs_busy, clk_i, rst_ni, res_valid_o, busy_q, "result while idle")
  `KFR_ASSERT_NEXT(a_finish_idles, clk_i, rst_ni, res_valid_o && res_o.finished, !busy_q,
                   "still busy after finish")
  `KFR_ASSERT_NOW(a_timeout_shape, clk_i, rst_ni, res_o.timed_out,
                  res_o.finished && !res_o.byte_written, "bad timeout result")
  `KFR_ASSERT_NEXT(a_start_arms, clk_i, rst_ni, item_valid_i && (item_i.cmd == CMD_START),
                   busy_q && (count_q == 8'd0) && (sum_q == 8'd0), "start did not arm")

endmodule

// ===== design/kfr_out_stage.sv =====
module kfr_out_stage
  import kfr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     res_valid_i,
  input  kfr_out_t res_i,
  output logic     stage_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output kfr_out_t out_data_o
);

  logic     valid_q, valid_d;
  kfr_out_t data_q;
  logic     load;

  assign stage_ready_o = !valid_q || out_ready_i;
  assign load          = res_valid_i && stage_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== design/kline_frame_receiver.sv =====
// K-line frame receiver with an 8-bit additive checksum. Send a start command to arm a
// receive with a millisecond timeout, an expected byte count (0 takes the count from the
// header byte: six low bits plus 4) and a verify flag. Each received byte while armed gives
// one result carrying the byte and its buffer index; the last byte, or a millisecond tick
// that exhausts the timeout, also carries the end status. Starts, unused codes, ticks that do not
// expire, and anything sent while idle give no result. The block takes one item per clock cycle
// while the result register is not stalled; an item passes from the input register to the result
// register, where its result is presented until it is taken. While a full result register
// is stalled, every item, even one that gives no result, waits in the input register, and
// input is held back once both registers are full.
module kline_frame_receiver
  import kfr_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 255
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  kfr_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output kfr_out_t out_data_o
);

  logic     item_valid;
  kfr_in_t  item;
  logic     stage_ready;
  logic     item_take;
  logic     res_valid;
  kfr_out_t res;

  // Advance an item only when the result register can take its result.
  assign item_take = item_valid && stage_ready;

  kfr_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_take_i  (item_take),
    .item_o       (item)
  );

  kfr_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_take),
    .item_i       (item),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  kfr_out_stage u_out_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_valid_i   (res_valid),
    .res_i         (res),
    .stage_ready_o (stage_ready),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

endmodule

// ===== tb/sv/kline_frame_receiver_tb.sv =====
module kline_frame_receiver_tb;
  import kfr_pkg::*;

  localparam int unsigned MAX_FRAME     = 255;
  localparam int unsigned N_ROWS        = 25;
  localparam int unsigned RANDOM_ITEMS  = 1350;
  localparam int unsigned DRAIN_CYCLES  = 12;
  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam kfr_cmd_e    CMD_UNUSED    = kfr_cmd_e'(2'd3);

  typedef struct {
    kfr_in_t  item;
    bit       typed;
    kfr_out_t result;
  } row_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  kfr_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  kfr_out_t out_data_o;

  kline_frame_receiver #(
    .MAX_FRAME_BYTES(MAX_FRAME)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Receiver-side copy of the frame state
  logic        rx_busy    = 1'b0;
  logic        len_known  = 1'b0;
  logic [7:0]  target_cnt = '0;
  logic [7:0]  rx_cnt     = '0;
  logic [7:0]  sum_acc    = '0;
  logic [7:0]  last_byte  = '0;
  logic [15:0] ms_left    = '0;
  logic        verify_on  = 1'b0;

  kfr_out_t    pending_results[$];
  int unsigned mismatch_cnt = 0;
  int unsigned frame_items  = 0;
  int unsigned burst_left   = 0;
  int unsigned cycle_cnt    = 0;
  logic [15:0] stall_bits   = 16'hFFFF;
  int unsigned stall_age    = 0;
  row_t        plan[N_ROWS];

  function automatic logic [7:0] clip_count(input int unsigned n);
    if (n > MAX_FRAME) n = MAX_FRAME;
    return n[7:0];
  endfunction

  function automatic void close_frame(input bit by_timeout, inout kfr_out_t res);
    logic [7:0] rest;
    bit         sum_ok;
    rest   = sum_acc - last_byte;
    sum_ok = (rx_cnt != 8'd0) && (rest == last_byte);
    res.finished      = 1'b1;
    res.timed_out     = by_timeout;
    res.checksum_ok   = sum_ok;
    res.result_length = (verify_on && !sum_ok) ? 8'd0 : rx_cnt;
    rx_busy = 1'b0;
  endfunction

  function automatic bit predict_rx_step(input kfr_in_t it, output kfr_out_t res);
    res = '0;
    if (it.cmd == CMD_START) begin
      rx_busy    = 1'b1;
      len_known  = (it.expected_length != 8'd0);
      target_cnt = clip_count(int'(it.expected_length));
      rx_cnt     = '0;
      sum_acc    = '0;
      last_byte  = '0;
      ms_left    = it.ms_budget;
      verify_on  = it.verify_frame;
      return 1'b0;
    end
    if (!rx_busy) return 1'b0;
    if (it.cmd == CMD_BYTE) begin
      res.byte_written = 1'b1;
      res.stored_byte  = it.rx_byte;
      res.byte_index   = rx_cnt;
      last_byte = it.rx_byte;
      sum_acc   = sum_acc + it.rx_byte;
      rx_cnt    = rx_cnt + 8'd1;
      if (!len_known) begin
        target_cnt = clip_count(int'((it.rx_byte & HDR_LEN_MASK) + HDR_EXTRA));
        len_known  = 1'b1;
      end else if (rx_cnt >= target_cnt) begin
        close_frame(1'b0, res);
      end
      return 1'b1;
    end
    if (it.cmd == CMD_TICK) begin
      if (ms_left <= 16'd1) begin
        ms_left = '0;
        close_frame(1'b1, res);
        return 1'b1;
      end
      ms_left = ms_left - 16'd1;
    end
    return 1'b0;
  endfunction

  function automatic string fmt_result(input kfr_out_t r);
    return $sformatf("wr=%0b byte=%02h idx=%0d fin=%0b tmo=%0b ok=%0b len=%0d",
                     r.byte_written, r.stored_byte, r.byte_index, r.finished,
                     r.timed_out, r.checksum_ok, r.result_length);
  endfunction

  function automatic kfr_in_t mk_item(input kfr_cmd_e c, input logic [7:0] b,
                                      input logic [7:0] len, input logic ver,
                                      input logic [15:0] tmo);
    kfr_in_t it;
    it.cmd             = c;
    it.rx_byte         = b;
    it.expected_length = len;
    it.verify_frame    = ver;
    it.ms_budget       = tmo;
    return it;
  endfunction

  // Send one item in bursts with random gaps, then predict on the transfer.
  task automatic send_item(input kfr_in_t item, input bit typed, input kfr_out_t typed_res);
    kfr_out_t    res;
    bit          has_res;
    bit          acted;
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    acted = (item.cmd == CMD_START) ||
            (rx_busy && (item.cmd == CMD_BYTE || item.cmd == CMD_TICK));
    if (acted) frame_items++;
    has_res = predict_rx_step(item, res);
    if (has_res) pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic send_noise(input kfr_cmd_e c);
    kfr_in_t it;
    it     = 35'({$urandom, $urandom});
    it.cmd = c;
    send_item(it, 1'b0, '0);
  endtask

  // Well-formed frame with random content; sometimes cut short or with a bad sum.
  task automatic run_frame();
    kfr_in_t     it;
    bit          from_header;
    bit          good_sum;
    int unsigned n_bytes;
    int unsigned pick;
    logic [7:0]  len;
    logic [7:0]  hdr;
    logic [7:0]  sum;
    logic [7:0]  b;
    logic [15:0] tmo;
    pick = $urandom_range(0, 39);
    if (pick == 0) len = 8'd255;
    else if (pick == 1) len = 8'($urandom_range(100, 254));
    else len = 8'($urandom_range(1, 12));
    from_header = ($urandom_range(0, 3) == 0);
    if (from_header) len = 8'd0;
    good_sum = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 7))
      0: tmo = 16'($urandom_range(0, 3));
      1: tmo = 16'hFFFF;
      2: tmo = 16'($urandom);
      default: tmo = 16'($urandom_range(20, 2000));
    endcase
    hdr     = 8'($urandom);
    n_bytes = from_header ? int'((hdr & HDR_LEN_MASK) + HDR_EXTRA) : int'(len);
    if ($urandom_range(0, 9) == 0) n_bytes = $urandom_range(0, n_bytes);
    it                 = 35'({$urandom, $urandom});
    it.cmd             = CMD_START;
    it.expected_length = len;
    it.verify_frame    = 1'($urandom_range(0, 1));
    it.ms_budget       = tmo;
    send_item(it, 1'b0, '0);
    sum = '0;
    for (int unsigned i = 0; i < n_bytes; i++) begin
      if ($urandom_range(0, 7) == 0) send_noise(CMD_TICK);
      if ($urandom_range(0, 39) == 0) send_noise(CMD_UNUSED);
      if (from_header && i == 0) b = hdr;
      else if (i == n_bytes - 1 && good_sum) b = sum;
      else b = 8'($urandom);
      it         = 35'({$urandom, $urandom});
      it.cmd     = CMD_BYTE;
      it.rx_byte = b;
      send_item(it, 1'b0, '0);
      sum = sum + b;
    end
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) send_noise(CMD_TICK);
  endtask

  // Output stall pattern: rotate a random mask, pick a new one when the age counter runs out.
  always @(posedge clk_i) begin
    if (stall_age == 0) begin
      stall_age  <= 48;
      stall_bits <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    end else begin
      stall_age  <= stall_age - 1;
      stall_bits <= {stall_bits[0], stall_bits[15:1]};
    end
    out_ready_i <= stall_bits[0];
  end

  always @(posedge clk_i) begin : check_results
    kfr_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: got %s", $time, fmt_result(out_data_o));
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o !== want) begin
          $display("%0t: result mismatch: expected %s, got %s", $time,
                   fmt_result(want), fmt_result(out_data_o));
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    plan = '{
      // idle: byte, tick and unused code are dropped
      '{mk_item(CMD_BYTE,   8'h5A, 8'd0,   1'b0, 16'd0),    1'b0, '0},
      '{mk_item(CMD_TICK,   8'h00, 8'd0,   1'b0, 16'd0),    1'b0, '0},
      '{mk_item(CMD_UNUSED, 8'hFF, 8'hFF,  1'b1, 16'hFFFF), 1'b0, '0},
      // explicit count of one completes on the first byte
      '{mk_item(CMD_START,  8'h00, 8'd1,   1'b0, 16'hFFFF), 1'b0, '0},
      '{mk_item(CMD_BYTE,   8'hFF, 8'd0,   1'b0, 16'd0),    1'b1,
        kfr_out_t'{1'b1, 8'hFF, 8'd0, 1'b1, 1'b0, 1'b0, 8'd1}},
      // zero timeout expires on the first tick with no bytes
      '{mk_item(CMD_START,  8'h00, 8'd0,   1'b1, 16'd0),    1'b0, '0},
      '{mk_item(CMD_TICK,   8'h00, 8'd0,   1'b0, 16'd0),    1'b1,
        kfr_out_t'{1'b0, 8'h00, 8'd0, 1'b1, 1'b1, 1'b0, 8'd0}},
      // header-length frame with a good sum
      '{mk_item(CMD_START,  8'h00, 8'd0,   1'b1, 16'd100),  1'b0, '0},
      '{mk_item(CMD_BYTE,   8'h00, 8'd0,   1'b0, 16'd0),    1'b1,
        kfr_out_t'{1'b1, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0}},
      '{mk_item(CMD_BYTE,   8'h12, 8'd0,   1'b0, 16'd0),    1'b1,
        kfr_out_t'{1'b1, 8'h12, 8'd1, 1'b0, 1'b0, 1'b0, 8'd0}},
      '{mk_item(CMD_TICK,   8'h00, 8'd0,   1'b0, 16'd0),    1'b0, '0},
      '{mk_item(CMD_UNUSED, 8'h00, 8'd0,   1'b0, 16'd0),    1'b0, '0},
      '{mk_item(CMD_BYTE,   8'h34, 8'd0,   1'b0, 16'd0),    1'b0, '0},
      '{mk_item(CMD_BYTE,   8'h46, 8'd0,   1'b0, 16'd0),    1'b1,
        kfr_out_t'{1'b1, 8'h46, 8'd3, 1'b1, 1'b0, 1'b1, 8'd4}},
      // largest header length, then restart while busy; bad sum in verify mode
      '{mk_item(CMD_START,  8'h00, 8'd0,   1'b1, 16'd5),    1'b0, '0},
      '{mk_item(CMD_BYTE,   8'hFF, 8'd0,   1'b0, 16'd0),    1'b0, '0},
      '{mk_item(CMD_BYTE,   8'h00, 8'd0,   1'b0, 16'd0),    1'b0, '0},
      '{mk_item(CMD_START,  8'h00, 8'd2,   1'b1, 16'hFFFF), 1'b0, '0},
      '{mk_item(CMD_BYTE,   8'h55, 8'd0,   1'b0, 16'd0),    1'b0, '0},
      '{mk_item(CMD_BYTE,   8'h54, 8'd0,   1'b0, 16'd0),    1'b1,
        kfr_out_t'{1'b1, 8'h54, 8'd1, 1'b1, 1'b0, 1'b0, 8'd0}},
      // largest count, timed out after one byte
      '{mk_item(CMD_START,  8'h00, 8'd255, 1'b0, 16'd2),    1'b0, '0},
      '{mk_item(CMD_BYTE,   8'hA5, 8'd0,   1'b0, 16'd0),    1'b0, '0},
      '{mk_item(CMD_TICK,   8'h00, 8'd0,   1'b0, 16'd0),    1'b0, '0},
      '{mk_item(CMD_TICK,   8'h00, 8'd0,   1'b0, 16'd0),    1'b1,
        kfr_out_t'{1'b0, 8'h00, 8'd0, 1'b1, 1'b1, 1'b0, 8'd1}},
      '{mk_item(CMD_TICK,   8'h00, 8'd0,   1'b0, 16'd0),    1'b0, '0}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned r = 0; r < N_ROWS; r++) begin
      send_item(plan[r].item, plan[r].typed, plan[r].result);
    end

    frame_items = 0;
    while (frame_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) send_noise(kfr_cmd_e'(2'($urandom_range(0, 3))));
      end
      run_frame();
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
